/* rtl/mcmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix chain minimum cost: shared package
// Holds the controller and sequencer states, the status codes and the
// control word that travels with each split down the cost pipeline.
// ----------------------------------------------------------------------------
package mcmc_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_HOLD
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_HDR,
        SQ_STEP,
        SQ_DRAIN
    } seq_state_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;
    localparam logic [1:0] STATUS_SAT      = 2'd3;

    // Idle cycles between two chain lengths, so that the last cost of one
    // length is written before the first read of the next length.
    localparam int unsigned DRAIN_CYCLES   = 3;
    localparam int unsigned DRAIN_CNT_BITS = 2;

    typedef struct packed {
        logic step;
        logic hdr;
        logic first;
        logic last_k;
        logic diag_l;
        logic diag_r;
        logic final_cell;
    } step_ctl_t;

endpackage
`default_nettype wire

/* rtl/matrix_chain_min_cost_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix chain minimum cost core
// Loads chain dimensions and returns the least scalar multiplication count
// of the whole chain, with a status.
// ----------------------------------------------------------------------------
// Each request carries one dimension; the request marked last closes the
// chain. A chain that is too short or too long, or that holds a single
// matrix, is answered in the cycle after its last request. Otherwise the
// sequencer issues one split per cycle, pausing for a header step before
// each sub-chain and a drain between chain lengths, and the two read ports
// of the cost table feed a four-stage cost pipeline. Dimensions are not
// taken while a chain is being solved. The tables need no clearing after
// reset.
// ----------------------------------------------------------------------------
module matrix_chain_min_cost_core #(
    parameter int MAX_MATRICES = 16,
    parameter int DIM_BITS     = 10,
    parameter int COST_BITS    = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic [DIM_BITS-1:0]   dim,
    input  wire logic                  last,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic      [COST_BITS-1:0]  min_cost,
    output logic      [1:0]            status
);

    import mcmc_pkg::*;

    localparam int IDX_BITS  = $clog2(MAX_MATRICES);
    localparam int DADR_BITS = $clog2(MAX_MATRICES + 1);
    localparam int CNT_BITS  = $clog2(MAX_MATRICES + 2);
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    ctrl_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0]   dim_count_reg, dim_count_next;
    logic                  overflow_reg, overflow_next;
    logic [IDX_BITS-1:0]   last_idx_reg, last_idx_next;
    logic [COST_BITS-1:0]  res_cost_reg, res_cost_next;
    logic                  result_valid_reg, result_valid_next;
    logic [COST_BITS-1:0]  min_cost_reg, min_cost_next;
    logic [1:0]            status_reg, status_next;

    logic                  accept;
    logic                  out_free;
    logic                  store_ok;
    logic [CNT_BITS-1:0]   cnt_after;
    logic [CNT_BITS-1:0]   n_minus_one;
    logic                  ovf;
    logic                  start;

    step_ctl_t             issue_ctl;
    logic [IDX_BITS-1:0]   issue_a, issue_b;
    logic [DADR_BITS-1:0]  dim_raddr_a, dim_raddr_b;
    logic [2*IDX_BITS-1:0] cost_raddr_l, cost_raddr_r;
    logic [DIM_BITS-1:0]   dim_rd_a, dim_rd_b;
    logic [COST_BITS-1:0]  cost_rd_l, cost_rd_r;
    logic                  cost_we;
    logic [2*IDX_BITS-1:0] cost_waddr;
    logic [COST_BITS-1:0]  cost_wdata;
    logic                  dp_done;
    logic [COST_BITS-1:0]  dp_cost;

    assign out_free    = !result_valid_reg || result_ready;
    assign item_ready  = (state_reg == ST_LOAD) && (!last || out_free);
    assign accept      = item_valid && item_ready;
    assign store_ok    = dim_count_reg < CNT_BITS'(MAX_MATRICES + 1);
    assign cnt_after   = store_ok ? (dim_count_reg + CNT_BITS'(1)) : dim_count_reg;
    assign n_minus_one = cnt_after - CNT_BITS'(2);
    assign ovf         = overflow_reg || !store_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            dim_count_reg    <= '0;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dim_count_reg    <= dim_count_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_idx_reg <= last_idx_next;
        res_cost_reg <= res_cost_next;
        min_cost_reg <= min_cost_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        dim_count_next    = dim_count_reg;
        overflow_next     = overflow_reg;
        last_idx_next     = last_idx_reg;
        res_cost_next     = res_cost_reg;
        result_valid_next = result_valid_reg && !result_ready;
        min_cost_next     = min_cost_reg;
        status_next       = status_reg;
        start             = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (!last)
                    begin
                        dim_count_next = cnt_after;
                        overflow_next  = ovf;
                    end
                    else
                    begin
                        dim_count_next = '0;
                        overflow_next  = 1'b0;
                        if (ovf)
                        begin
                            result_valid_next = 1'b1;
                            min_cost_next     = '0;
                            status_next       = STATUS_TOO_MANY;
                        end
                        else if (cnt_after < CNT_BITS'(2))
                        begin
                            result_valid_next = 1'b1;
                            min_cost_next     = '0;
                            status_next       = STATUS_SHORT;
                        end
                        else if (cnt_after == CNT_BITS'(2))
                        begin
                            result_valid_next = 1'b1;
                            min_cost_next     = '0;
                            status_next       = STATUS_OK;
                        end
                        else
                        begin
                            start         = 1'b1;
                            last_idx_next = n_minus_one[IDX_BITS-1:0];
                            state_next    = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (dp_done)
                begin
                    res_cost_next = dp_cost;
                    state_next    = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    min_cost_next     = res_cost_reg;
                    status_next       = (res_cost_reg == COST_MAX) ? STATUS_SAT : STATUS_OK;
                    state_next        = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign min_cost     = min_cost_reg;
    assign status       = status_reg;

    mcmc_dim_store #(
        .DEPTH     (MAX_MATRICES + 1),
        .ADDR_BITS (DADR_BITS),
        .DIM_BITS  (DIM_BITS)
    ) u_dim_store (
        .clk     (clk),
        .we      (accept && store_ok),
        .waddr   (dim_count_reg[DADR_BITS-1:0]),
        .wdata   (dim),
        .raddr_a (dim_raddr_a),
        .raddr_b (dim_raddr_b),
        .rdata_a (dim_rd_a),
        .rdata_b (dim_rd_b)
    );

    mcmc_cost_store #(
        .IDX_BITS  (IDX_BITS),
        .COST_BITS (COST_BITS)
    ) u_cost_store (
        .clk     (clk),
        .we      (cost_we),
        .waddr   (cost_waddr),
        .wdata   (cost_wdata),
        .raddr_l (cost_raddr_l),
        .raddr_r (cost_raddr_r),
        .rdata_l (cost_rd_l),
        .rdata_r (cost_rd_r)
    );

    mcmc_seq #(
        .IDX_BITS  (IDX_BITS),
        .DADR_BITS (DADR_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_idx     (last_idx_next),
        .issue_ctl    (issue_ctl),
        .issue_a      (issue_a),
        .issue_b      (issue_b),
        .dim_raddr_a  (dim_raddr_a),
        .dim_raddr_b  (dim_raddr_b),
        .cost_raddr_l (cost_raddr_l),
        .cost_raddr_r (cost_raddr_r)
    );

    mcmc_datapath #(
        .IDX_BITS  (IDX_BITS),
        .DIM_BITS  (DIM_BITS),
        .COST_BITS (COST_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_ctl (issue_ctl),
        .issue_a   (issue_a),
        .issue_b   (issue_b),
        .dim_rd_a  (dim_rd_a),
        .dim_rd_b  (dim_rd_b),
        .cost_rd_l (cost_rd_l),
        .cost_rd_r (cost_rd_r),
        .wr_en     (cost_we),
        .wr_addr   (cost_waddr),
        .wr_data   (cost_wdata),
        .done      (dp_done),
        .done_cost (dp_cost)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STATUS_SAT) |-> (min_cost == COST_MAX))
        else $error("Saturated status without a saturated cost.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((status == STATUS_SHORT) || (status == STATUS_TOO_MANY))
        |-> (min_cost == '0))
        else $error("Rejected chain reported a non-zero cost.");

    assert property (@(posedge clk) disable iff (!rst_n)
        dp_done |-> (state_reg == ST_RUN))
        else $error("Cost pipeline finished outside a run.");

    assert property (@(posedge clk) disable iff (!rst_n)
        dim_count_reg <= CNT_BITS'(MAX_MATRICES + 1))
        else $error("Dimension count beyond the store depth.");
`endif

endmodule
`default_nettype wire

/* rtl/mcmc_dim_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix chain minimum cost: dimension store
// Synchronous memory of chain dimensions with one write port and two
// registered read ports.
// ----------------------------------------------------------------------------
module mcmc_dim_store #(
    parameter int DEPTH     = 17,
    parameter int ADDR_BITS = 5,
    parameter int DIM_BITS  = 10
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DIM_BITS-1:0]  wdata,
    input  wire logic [ADDR_BITS-1:0] raddr_a,
    input  wire logic [ADDR_BITS-1:0] raddr_b,
    output logic      [DIM_BITS-1:0]  rdata_a,
    output logic      [DIM_BITS-1:0]  rdata_b
);

    logic [DIM_BITS-1:0] dim_mem [DEPTH];
    logic [DIM_BITS-1:0] rd_a_reg;
    logic [DIM_BITS-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            dim_mem[waddr] <= wdata;
        end
        rd_a_reg <= dim_mem[raddr_a];
        rd_b_reg <= dim_mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule
`default_nettype wire

/* rtl/mcmc_cost_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix chain minimum cost: cost table
// Synchronous memory of sub-chain costs, addressed by first and last matrix,
// with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mcmc_cost_store #(
    parameter int IDX_BITS  = 4,
    parameter int COST_BITS = 48
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [2*IDX_BITS-1:0]   waddr,
    input  wire logic [COST_BITS-1:0]    wdata,
    input  wire logic [2*IDX_BITS-1:0]   raddr_l,
    input  wire logic [2*IDX_BITS-1:0]   raddr_r,
    output logic      [COST_BITS-1:0]    rdata_l,
    output logic      [COST_BITS-1:0]    rdata_r
);

    localparam int DEPTH = 2 ** (2 * IDX_BITS);

    logic [COST_BITS-1:0] cost_mem [DEPTH];
    logic [COST_BITS-1:0] rd_l_reg;
    logic [COST_BITS-1:0] rd_r_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cost_mem[waddr] <= wdata;
        end
        rd_l_reg <= cost_mem[raddr_l];
        rd_r_reg <= cost_mem[raddr_r];
    end

    assign rdata_l = rd_l_reg;
    assign rdata_r = rd_r_reg;

endmodule
`default_nettype wire

/* rtl/mcmc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix chain minimum cost: split sequencer
// Walks the chain lengths, the sub-chains of each length and the split
// points of each sub-chain, issuing one memory access per cycle outside the drain.
// ----------------------------------------------------------------------------
module mcmc_seq #(
    parameter int IDX_BITS  = 4,
    parameter int DADR_BITS = 5
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [IDX_BITS-1:0]       last_idx,
    output mcmc_pkg::step_ctl_t            issue_ctl,
    output logic      [IDX_BITS-1:0]       issue_a,
    output logic      [IDX_BITS-1:0]       issue_b,
    output logic      [DADR_BITS-1:0]      dim_raddr_a,
    output logic      [DADR_BITS-1:0]      dim_raddr_b,
    output logic      [2*IDX_BITS-1:0]     cost_raddr_l,
    output logic      [2*IDX_BITS-1:0]     cost_raddr_r
);

    import mcmc_pkg::*;

    seq_state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]       span_reg, span_next;
    logic [IDX_BITS-1:0]       a_reg, a_next;
    logic [IDX_BITS-1:0]       k_reg, k_next;
    logic [DRAIN_CNT_BITS-1:0] drain_reg, drain_next;
    logic [IDX_BITS-1:0]       b_idx;
    logic [IDX_BITS-1:0]       k_plus;
    step_ctl_t                 ctl;

    assign b_idx  = a_reg + span_reg;
    assign k_plus = k_reg + IDX_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            span_reg  <= '0;
            a_reg     <= '0;
            k_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            span_reg  <= span_next;
            a_reg     <= a_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        span_next    = span_reg;
        a_next       = a_reg;
        k_next       = k_reg;
        drain_next   = drain_reg;
        ctl          = '0;
        dim_raddr_a  = DADR_BITS'(k_reg) + DADR_BITS'(1);
        dim_raddr_b  = DADR_BITS'(a_reg);
        cost_raddr_l = {a_reg, k_reg};
        cost_raddr_r = {k_plus, b_idx};

        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    span_next  = IDX_BITS'(1);
                    a_next     = '0;
                    state_next = SQ_HDR;
                end
            end
            SQ_HDR:
            begin
                ctl.hdr     = 1'b1;
                dim_raddr_a = DADR_BITS'(b_idx) + DADR_BITS'(1);
                k_next      = a_reg;
                state_next  = SQ_STEP;
            end
            SQ_STEP:
            begin
                ctl.step       = 1'b1;
                ctl.first      = (k_reg == a_reg);
                ctl.last_k     = (k_plus == b_idx);
                ctl.diag_l     = (k_reg == a_reg);
                ctl.diag_r     = (k_plus == b_idx);
                ctl.final_cell = (a_reg == '0) && (b_idx == last_idx);
                if (k_plus == b_idx)
                begin
                    if (b_idx == last_idx)
                    begin
                        if (a_reg == '0)
                        begin
                            state_next = SQ_IDLE;
                        end
                        else
                        begin
                            span_next  = span_reg + IDX_BITS'(1);
                            a_next     = '0;
                            drain_next = '0;
                            state_next = SQ_DRAIN;
                        end
                    end
                    else
                    begin
                        a_next     = a_reg + IDX_BITS'(1);
                        state_next = SQ_HDR;
                    end
                end
                else
                begin
                    k_next = k_plus;
                end
            end
            SQ_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_CNT_BITS'(1);
                if (drain_reg == DRAIN_CNT_BITS'(DRAIN_CYCLES - 1))
                begin
                    state_next = SQ_HDR;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign issue_ctl = ctl;
    assign issue_a   = a_reg;
    assign issue_b   = b_idx;

endmodule
`default_nettype wire

/* rtl/mcmc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix chain minimum cost: cost pipeline
// Forms the saturated cost of each split from the memory read data, keeps
// the running minimum of a sub-chain and writes it back at its last split.
// ----------------------------------------------------------------------------
module mcmc_datapath #(
    parameter int IDX_BITS  = 4,
    parameter int DIM_BITS  = 10,
    parameter int COST_BITS = 48
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mcmc_pkg::step_ctl_t     issue_ctl,
    input  wire logic [IDX_BITS-1:0]     issue_a,
    input  wire logic [IDX_BITS-1:0]     issue_b,
    input  wire logic [DIM_BITS-1:0]     dim_rd_a,
    input  wire logic [DIM_BITS-1:0]     dim_rd_b,
    input  wire logic [COST_BITS-1:0]    cost_rd_l,
    input  wire logic [COST_BITS-1:0]    cost_rd_r,
    output logic                         wr_en,
    output logic      [2*IDX_BITS-1:0]   wr_addr,
    output logic      [COST_BITS-1:0]    wr_data,
    output logic                         done,
    output logic      [COST_BITS-1:0]    done_cost
);

    import mcmc_pkg::*;

    localparam int PROD_BITS = 3 * DIM_BITS;
    localparam int WIDE_BITS = (PROD_BITS > COST_BITS) ? PROD_BITS : COST_BITS;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    step_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [IDX_BITS-1:0] a1_reg, b1_reg, a2_reg, b2_reg, a3_reg, b3_reg, a4_reg, b4_reg;

    logic [DIM_BITS-1:0]   pa_reg, pa_next;
    logic [DIM_BITS-1:0]   pb_reg, pb_next;
    logic [2*DIM_BITS-1:0] m1_reg;
    logic [DIM_BITS-1:0]   pb2_reg;
    logic [COST_BITS-1:0]  csum2_reg, csum3_reg;
    logic [COST_BITS-1:0]  prod3_reg;
    logic [COST_BITS-1:0]  q4_reg;
    logic [COST_BITS-1:0]  best_reg, best_next;

    logic [COST_BITS-1:0]  cost_l, cost_r;
    logic [COST_BITS:0]    csum_wide, q_wide;
    logic [COST_BITS-1:0]  csum_sat, q_sat;
    logic [PROD_BITS-1:0]  prod;
    logic [WIDE_BITS-1:0]  prod_wide;
    logic [COST_BITS-1:0]  prod_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= issue_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_comb
    begin
        pa_next = pa_reg;
        pb_next = pb_reg;
        if (ctl1_reg.hdr)
        begin
            pa_next = dim_rd_b;
            pb_next = dim_rd_a;
        end
        cost_l    = ctl1_reg.diag_l ? '0 : cost_rd_l;
        cost_r    = ctl1_reg.diag_r ? '0 : cost_rd_r;
        csum_wide = {1'b0, cost_l} + {1'b0, cost_r};
        csum_sat  = (csum_wide >= {1'b0, COST_MAX}) ? COST_MAX : csum_wide[COST_BITS-1:0];

        prod      = PROD_BITS'(m1_reg) * PROD_BITS'(pb2_reg);
        prod_wide = WIDE_BITS'(prod);
        prod_sat  = (prod_wide > WIDE_BITS'(COST_MAX)) ? COST_MAX
                                                       : prod_wide[COST_BITS-1:0];

        q_wide = {1'b0, csum3_reg} + {1'b0, prod3_reg};
        q_sat  = (q_wide >= {1'b0, COST_MAX}) ? COST_MAX : q_wide[COST_BITS-1:0];

        best_next = (ctl4_reg.first || (q4_reg < best_reg)) ? q4_reg : best_reg;
    end

    always_ff @(posedge clk)
    begin
        a1_reg    <= issue_a;
        b1_reg    <= issue_b;
        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        a3_reg    <= a2_reg;
        b3_reg    <= b2_reg;
        a4_reg    <= a3_reg;
        b4_reg    <= b3_reg;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        m1_reg    <= (2*DIM_BITS)'(pa_reg) * (2*DIM_BITS)'(dim_rd_a);
        pb2_reg   <= pb_reg;
        csum2_reg <= csum_sat;
        csum3_reg <= csum2_reg;
        prod3_reg <= prod_sat;
        q4_reg    <= q_sat;
        if (ctl4_reg.step)
        begin
            best_reg <= best_next;
        end
    end

    assign wr_en     = ctl4_reg.step && ctl4_reg.last_k;
    assign wr_addr   = {a4_reg, b4_reg};
    assign wr_data   = best_next;
    assign done      = ctl4_reg.step && ctl4_reg.last_k && ctl4_reg.final_cell;
    assign done_cost = best_next;

endmodule
`default_nettype wire
